[design/two_wire_display_serial_master_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the two-wire display serial master core
// Concurrent checks clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef TWO_WIRE_DISPLAY_SERIAL_MASTER_CORE_DEFINES_SVH
`define TWO_WIRE_DISPLAY_SERIAL_MASTER_CORE_DEFINES_SVH

// property that must hold at every clock edge
`define TWDSM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m: check failed");

// condition in one cycle implies a consequence in the next
`define TWDSM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[design/twdsm_pkg.sv]
// ---------------------------------------------------------------------------
// twdsm_pkg
// Op codes, phase numbers, pin and response word types and the pin
// table for the two-wire display serial master.
// ---------------------------------------------------------------------------
package twdsm_pkg;

   // command / active operation codes
   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   // phase numbers of note
   localparam logic [4:0] PH_FIRST      = 5'd0;
   localparam logic [4:0] PH_START_LAST = 5'd1;
   localparam logic [4:0] PH_STOP_LAST  = 5'd3;
   localparam logic [4:0] PH_ACK_LOW    = 5'd16;
   localparam logic [4:0] PH_ACK_WAIT   = 5'd17;
   localparam logic [4:0] PH_ACK_HIGH   = 5'd18;

   // configuration register indexes
   localparam logic [1:0] CSR_PHASE_TICKS = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd1;

   typedef struct packed {
      logic drv;
      logic lvl;
      logic clk;
   } pins_type;

   // response word, MSB first (clk_level lands in bit 0)
   typedef struct packed {
      logic       ack_missing;
      logic [7:0] read_byte;
      logic       done;
      logic       busy;
      logic       dio_drive;
      logic       dio_level;
      logic       clk_level;
   } rsp_word_type;

   // final phase of a sequence
   function automatic logic [4:0] last_phase(input logic [2:0] op);
      logic [4:0] ph;
      case (op)
         OP_START: ph = PH_START_LAST;
         OP_STOP:  ph = PH_STOP_LAST;
         default:  ph = PH_ACK_HIGH;
      endcase
      return ph;
   endfunction

   // pin levels for a phase of an operation
   function automatic pins_type phase_pins(input logic [2:0] op, input logic [4:0] ph,
                                           input logic [7:0] shift, input logic lvl_prev);
      pins_type p;
      logic     bit_val;
      p       = '{drv: 1'b1, lvl: 1'b1, clk: 1'b1};
      bit_val = shift[ph[3:1]];
      case (op)
         OP_START: begin
            if (ph == PH_FIRST) p = '{drv: 1'b1, lvl: 1'b1, clk: 1'b1};
            else                p = '{drv: 1'b1, lvl: 1'b0, clk: 1'b1};
         end
         OP_STOP: begin
            case (ph[1:0])
               2'd0:    p = '{drv: 1'b1, lvl: lvl_prev, clk: 1'b0};
               2'd1:    p = '{drv: 1'b1, lvl: 1'b0, clk: 1'b0};
               2'd2:    p = '{drv: 1'b1, lvl: 1'b0, clk: 1'b1};
               default: p = '{drv: 1'b1, lvl: 1'b1, clk: 1'b1};
            endcase
         end
         default: begin
            if (ph < PH_ACK_LOW) begin
               // bit phases: even is clock low, odd is clock high
               if (op == OP_WRITE) p = '{drv: 1'b1, lvl: bit_val, clk: ph[0]};
               else                p = '{drv: 1'b0, lvl: 1'b0, clk: ph[0]};
            end else if (ph == PH_ACK_HIGH) begin
               p = '{drv: 1'b0, lvl: 1'b0, clk: 1'b1};
            end else begin
               p = '{drv: 1'b0, lvl: 1'b0, clk: 1'b0};
            end
         end
      endcase
      return p;
   endfunction

endpackage

[design/two_wire_display_serial_master_core.sv]
// ---------------------------------------------------------------------------
// two_wire_display_serial_master_core
// Each accepted tick word has its response word registered in the output buffer.
// Throughput: one tick word per cycle while the skid entry is free; the sequencer update is single pass.
// A two-entry output buffer keeps the input open while one response waits.
// Synchronous active-high reset: idle, clock high, data high and driven.
// ---------------------------------------------------------------------------
`include "two_wire_display_serial_master_core_defines.svh"

module two_wire_display_serial_master_core (
   input  logic        clock,
   input  logic        reset,
   // tick word in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_byte[7:0], dio_sample[8], zero pad
   input  logic [2:0]  req_tuser,  // command[2:0]
   // response word out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // clk_level, dio_level, dio_drive, busy_res,
                                   // done_res, read_byte[12:5], ack_missing, pad
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import twdsm_pkg::*;

   // configuration
   logic [7:0]   phase_ticks_ff;
   logic [15:0]  ack_timeout_ff;

   // sequencer state
   logic [2:0]   op_ff, op_in;
   logic [4:0]   phase_ff, phase_in;
   logic [7:0]   shift_ff, shift_in;
   logic [7:0]   rcv_ff, rcv_in;
   logic [7:0]   tick_ff, tick_in;
   logic [15:0]  ack_cnt_ff, ack_cnt_in;
   pins_type     pins_ff, pins_in;
   logic         ack_err_ff, ack_err_in;

   // output buffer
   rsp_word_type out_ff, skid_ff, word_in;
   logic         out_vld_ff, skid_vld_ff;

   logic         push, pop;
   logic [2:0]   cmd;
   logic [7:0]   data;
   logic         sample;
   logic [7:0]   pt;
   logic         do_enter;
   logic [4:0]   enter_ph;
   logic [15:0]  cnt_inc;
   logic         done;

   assign cmd    = req_tuser;
   assign data   = req_tdata[7:0];
   assign sample = req_tdata[8];
   assign pt     = (phase_ticks_ff == 8'd0) ? 8'd1 : phase_ticks_ff;

   assign req_tready = !skid_vld_ff;
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = out_vld_ff;
   assign pop        = out_vld_ff && rsp_tready;
   assign rsp_tdata  = {2'b00, out_ff};

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= 8'd1;
         ack_timeout_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_TICKS: phase_ticks_ff <= csr_wdata[7:0];
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer next state for one tick
   always_comb begin
      op_in      = op_ff;
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      rcv_in     = rcv_ff;
      tick_in    = tick_ff;
      ack_cnt_in = ack_cnt_ff;
      pins_in    = pins_ff;
      ack_err_in = ack_err_ff;
      do_enter   = 1'b0;
      enter_ph   = PH_FIRST;
      done       = 1'b0;
      cnt_inc    = (ack_cnt_ff == 16'hFFFF) ? ack_cnt_ff : ack_cnt_ff + 16'd1;

      if (op_ff == OP_IDLE) begin
         // launch a command; codes above stop are plain ticks
         if (cmd inside {OP_START, OP_WRITE, OP_READ, OP_STOP}) begin
            op_in    = cmd;
            shift_in = data;
            do_enter = 1'b1;
            enter_ph = PH_FIRST;
         end
      end else if ((op_ff == OP_WRITE || op_ff == OP_READ) && phase_ff == PH_ACK_WAIT) begin
         // acknowledge wait with optional timeout
         if (!sample) begin
            do_enter = 1'b1;
            enter_ph = PH_ACK_HIGH;
         end else begin
            ack_cnt_in = cnt_inc;
            if (ack_timeout_ff != 16'd0 && cnt_inc >= ack_timeout_ff) begin
               ack_err_in = 1'b1;
               do_enter   = 1'b1;
               enter_ph   = PH_ACK_HIGH;
            end
         end
      end else if (tick_ff >= pt) begin
         // phase over: sample read bit at end of clock high
         if (op_ff == OP_READ && phase_ff < PH_ACK_LOW && phase_ff[0])
            rcv_in = {sample, rcv_ff[7:1]};
         if (phase_ff >= last_phase(op_ff)) begin
            op_in    = OP_IDLE;
            phase_in = PH_FIRST;
            tick_in  = 8'd0;
            done     = 1'b1;
         end else begin
            do_enter = 1'b1;
            enter_ph = phase_ff + 5'd1;
         end
      end else begin
         tick_in = tick_ff + 8'd1;
      end

      // phase entry
      if (do_enter) begin
         phase_in = enter_ph;
         pins_in  = phase_pins(op_in, enter_ph, shift_in, pins_ff.lvl);
         tick_in  = 8'd1;
         if ((op_in == OP_WRITE || op_in == OP_READ) && enter_ph == PH_ACK_WAIT) begin
            ack_cnt_in = 16'd0;
            ack_err_in = 1'b0;
         end
      end

      word_in.clk_level   = pins_in.clk;
      word_in.dio_level   = pins_in.lvl;
      word_in.dio_drive   = pins_in.drv;
      word_in.busy        = (op_in != OP_IDLE);
      word_in.done        = done;
      word_in.read_byte   = rcv_in;
      word_in.ack_missing = ack_err_in;
   end

   // sequencer registers, advanced once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= OP_IDLE;
         phase_ff   <= PH_FIRST;
         shift_ff   <= 8'd0;
         rcv_ff     <= 8'd0;
         tick_ff    <= 8'd0;
         ack_cnt_ff <= 16'd0;
         pins_ff    <= '{drv: 1'b1, lvl: 1'b1, clk: 1'b1};
         ack_err_ff <= 1'b0;
      end else if (push) begin
         op_ff      <= op_in;
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         rcv_ff     <= rcv_in;
         tick_ff    <= tick_in;
         ack_cnt_ff <= ack_cnt_in;
         pins_ff    <= pins_in;
         ack_err_ff <= ack_err_in;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || pop) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= push;
         end
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || pop) begin
         if (skid_vld_ff) out_ff <= skid_ff;
         else if (push)   out_ff <= word_in;
      end else if (push) begin
         skid_ff <= word_in;
      end
   end

   // checks
   `TWDSM_ASSERT(a_skid_has_out, !skid_vld_ff || out_vld_ff)
   `TWDSM_ASSERT(a_done_not_busy, !out_vld_ff || !(out_ff.done && out_ff.busy))
   `TWDSM_ASSERT(a_idle_clean, op_ff != OP_IDLE || (phase_ff == PH_FIRST && tick_ff == 8'd0))
   `TWDSM_ASSERT_NEXT(a_stall_to_skid, out_vld_ff && !rsp_tready && push, skid_vld_ff)

endmodule

[tb/tb_two_wire_display_serial_master_core.sv]
// ---------------------------------------------------------------------------
// tb_two_wire_display_serial_master_core
// Self-checking bench for the two-wire display serial master. Each tick word
// sent in is run through a behavioral copy of the sequencer, and every
// response word is compared field by field against the oldest pending
// prediction. A short directed table comes first. Random phases follow, each
// under its own phase_ticks / ack_timeout setting. Both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_two_wire_display_serial_master_core;
   import twdsm_pkg::*;

   // command names beside the package ones
   localparam logic [2:0] CMD_TICK     = OP_IDLE;
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // response words that are obvious by inspection
   localparam logic [13:0] WORD_IDLE_RESET = 14'h0007;  // clk, lvl, drv high
   localparam logic [13:0] WORD_START_HEAD = 14'h000F;  // same, plus busy

   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  data;
      logic        smp;
      logic [7:0]  reps;
      logic        typed;
      logic [13:0] want;
   } stim_row_type;

   // DUT signals, the inputs all known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_PHASE_TICKS;
   logic [15:0] csr_wdata  = '0;

   // bench control
   bit          quiet    = 1'b0;   // no idling on either side
   bit          hold_req = 1'b0;   // receiver long hold-off request
   int unsigned err_count = 0;
   rsp_word_type pending_words[$];

   // sequencer copy: configuration and state
   logic [7:0]  cfg_ticks;
   logic [15:0] cfg_timeout;
   logic [2:0]  seq_op;
   logic [4:0]  seq_phase;
   logic [7:0]  seq_shift;
   logic [7:0]  seq_rx;
   logic [7:0]  seq_count;
   logic [15:0] seq_wait;
   pins_type    seq_pins;
   logic        seq_ack_err;

   stim_row_type dir_rows [16];

   two_wire_display_serial_master_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_byte[7:0], dio_sample[8]
      .req_tuser  (req_tuser),   // command[2:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // clk, lvl, drv, busy, done, read_byte, ack_missing
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("tb_two_wire_display_serial_master_core: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // sequencer copy
   // ------------------------------------------------------------------------
   function automatic logic is_byte_op(input logic [2:0] op);
      return (op == OP_WRITE) || (op == OP_READ);
   endfunction

   function automatic logic [4:0] final_phase_of(input logic [2:0] op);
      if (op == OP_START) return PH_START_LAST;
      if (op == OP_STOP)  return PH_STOP_LAST;
      return PH_ACK_HIGH;
   endfunction

   // pin levels on entry to a phase; stop's first phase keeps the data level
   function automatic pins_type pins_for(input logic [2:0] op, input logic [4:0] ph);
      pins_type p;
      p = '{drv: 1'b0, lvl: 1'b0, clk: 1'b0};
      if (op == OP_START) begin
         p = '{drv: 1'b1, lvl: (ph == PH_FIRST), clk: 1'b1};
      end else if (op == OP_STOP) begin
         case (ph)
            5'd0:    p = '{drv: 1'b1, lvl: seq_pins.lvl, clk: 1'b0};
            5'd1:    p = '{drv: 1'b1, lvl: 1'b0, clk: 1'b0};
            5'd2:    p = '{drv: 1'b1, lvl: 1'b0, clk: 1'b1};
            default: p = '{drv: 1'b1, lvl: 1'b1, clk: 1'b1};
         endcase
      end else if (ph < PH_ACK_LOW) begin
         p.clk = ph[0];
         if (op == OP_WRITE) begin
            p.drv = 1'b1;
            p.lvl = seq_shift[ph[3:1]];
         end
      end else if (ph == PH_ACK_HIGH) begin
         p.clk = 1'b1;
      end
      return p;
   endfunction

   task automatic enter_phase(input logic [4:0] ph);
      seq_phase = ph;
      seq_pins  = pins_for(seq_op, ph);
      seq_count = 8'd1;
      if (is_byte_op(seq_op) && ph == PH_ACK_WAIT) begin
         seq_wait    = '0;
         seq_ack_err = 1'b0;
      end
   endtask

   task automatic reset_sequencer();
      cfg_ticks   = 8'd1;
      cfg_timeout = '0;
      seq_op      = OP_IDLE;
      seq_phase   = PH_FIRST;
      seq_shift   = '0;
      seq_rx      = '0;
      seq_count   = '0;
      seq_wait    = '0;
      seq_pins    = '{drv: 1'b1, lvl: 1'b1, clk: 1'b1};
      seq_ack_err = 1'b0;
   endtask

   // one tick: advance the sequencer and form the response word
   task automatic sequencer_tick(input logic [2:0] cmd, input logic [7:0] data,
                                 input logic smp, output rsp_word_type word);
      logic [7:0] span;
      logic       fin;
      span = (cfg_ticks == 8'd0) ? 8'd1 : cfg_ticks;
      fin  = 1'b0;
      if (seq_op == OP_IDLE) begin
         if (cmd >= OP_START && cmd <= OP_STOP) begin
            seq_op    = cmd;
            seq_shift = data;
            enter_phase(PH_FIRST);
         end
      end else if (is_byte_op(seq_op) && seq_phase == PH_ACK_WAIT) begin
         if (!smp) begin
            enter_phase(PH_ACK_HIGH);
         end else begin
            if (seq_wait != 16'hFFFF) seq_wait = seq_wait + 16'd1;
            if (cfg_timeout != 16'd0 && seq_wait >= cfg_timeout) begin
               seq_ack_err = 1'b1;
               enter_phase(PH_ACK_HIGH);
            end
         end
      end else if (seq_count >= span) begin
         // read bit is taken as the clock-high phase ends
         if (seq_op == OP_READ && seq_phase < PH_ACK_LOW && seq_phase[0])
            seq_rx = {smp, seq_rx[7:1]};
         if (seq_phase >= final_phase_of(seq_op)) begin
            seq_op    = OP_IDLE;
            seq_phase = PH_FIRST;
            seq_count = '0;
            fin       = 1'b1;
         end else begin
            enter_phase(seq_phase + 5'd1);
         end
      end else begin
         seq_count = seq_count + 8'd1;
      end
      word.clk_level   = seq_pins.clk;
      word.dio_level   = seq_pins.lvl;
      word.dio_drive   = seq_pins.drv;
      word.busy        = (seq_op != OP_IDLE);
      word.done        = fin;
      word.read_byte   = seq_rx;
      word.ack_missing = seq_ack_err;
   endtask

   // ------------------------------------------------------------------------
   // response check
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[13:0];
         if (pending_words.size() == 0) begin
            $display("%0t: response word with nothing pending, expected none, actual %h",
                     $time, got);
            err_count++;
         end else begin
            want = pending_words.pop_front();
            check_field("clk_level", 8'(want.clk_level), 8'(got.clk_level));
            check_field("dio_level", 8'(want.dio_level), 8'(got.dio_level));
            check_field("dio_drive", 8'(want.dio_drive), 8'(got.dio_drive));
            check_field("busy_res", 8'(want.busy), 8'(got.busy));
            check_field("done_res", 8'(want.done), 8'(got.done));
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random back-pressure, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 34) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------
   // offer one tick word; returns in the step of its acceptance
   task automatic send_word(input logic [2:0] cmd, input logic [7:0] data,
                            input logic smp, input logic typed,
                            input rsp_word_type want);
      rsp_word_type word;
      if (!quiet) begin
         while ($urandom_range(0, 99) < 34) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, smp, data};
      do @(posedge clock); while (!req_tready);
      sequencer_tick(cmd, data, smp, word);
      pending_words.push_back(typed ? want : word);
   endtask

   // finish any running sequence, then wait for every response word
   task automatic settle_idle();
      while (seq_op != OP_IDLE)
         send_word(CMD_TICK, 8'($urandom), 1'b0, 1'b0, '0);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] ticks, input logic [15:0] timeout);
      csr_we    <= 1'b1;
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= {8'd0, ticks};
      @(posedge clock);
      cfg_ticks = ticks;
      csr_index <= CSR_ACK_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      cfg_timeout = timeout;
      csr_we <= 1'b0;
   endtask

   // mostly well-formed commands while idle, light noise while busy
   task automatic pick_item(input bit short_ops, output logic [2:0] cmd,
                            output logic [7:0] data, output logic smp);
      int r;
      r = $urandom_range(0, 99);
      if (seq_op == OP_IDLE) begin
         if (r < 70) begin
            if (short_ops) cmd = $urandom_range(0, 1) ? OP_START : OP_STOP;
            else           cmd = 3'($urandom_range(OP_START, OP_STOP));
         end else if (r < 80) begin
            cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
         end else begin
            cmd = CMD_TICK;
         end
      end else begin
         cmd = (r < 85) ? CMD_TICK : 3'($urandom_range(0, 7));
      end
      data = 8'($urandom);
      // lean toward a missing acknowledge so the timeout gets exercised
      if (is_byte_op(seq_op) && seq_phase == PH_ACK_WAIT)
         smp = ($urandom_range(0, 99) < 55);
      else
         smp = 1'($urandom_range(0, 1));
   endtask

   task automatic run_phase(input logic [7:0] ticks, input logic [15:0] timeout,
                            input int items, input bit calm, input bit squeeze,
                            input bit short_ops);
      logic [2:0] cmd;
      logic [7:0] data;
      logic       smp;
      set_config(ticks, timeout);
      quiet = calm;
      for (int i = 0; i < items; i++) begin
         if (squeeze && i == 40) hold_req = 1'b1;
         pick_item(short_ops, cmd, data, smp);
         send_word(cmd, data, smp, 1'b0, '0);
      end
      settle_idle();
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset_sequencer();
      dir_rows = '{
         // idle tick and the unused codes right after reset
         '{CMD_TICK,     8'h00, 1'b0, 8'd1,  1'b1, WORD_IDLE_RESET},
         '{CMD_SPARE_LO, 8'hFF, 1'b1, 8'd1,  1'b1, WORD_IDLE_RESET},
         '{CMD_SPARE_HI, 8'hAA, 1'b1, 8'd1,  1'b1, WORD_IDLE_RESET},
         // start, with a write offered while busy
         '{OP_START,     8'h00, 1'b1, 8'd1,  1'b1, WORD_START_HEAD},
         '{OP_WRITE,     8'h5A, 1'b1, 8'd1,  1'b0, 14'd0},
         '{CMD_TICK,     8'h00, 1'b0, 8'd2,  1'b0, 14'd0},
         // write all ones, ack at once
         '{OP_WRITE,     8'hFF, 1'b0, 8'd1,  1'b0, 14'd0},
         '{CMD_TICK,     8'hFF, 1'b0, 8'd20, 1'b0, 14'd0},
         // write all zeros, ack held off with no timeout
         '{OP_WRITE,     8'h00, 1'b1, 8'd1,  1'b0, 14'd0},
         '{CMD_TICK,     8'h00, 1'b1, 8'd19, 1'b0, 14'd0},
         '{CMD_TICK,     8'h00, 1'b0, 8'd3,  1'b0, 14'd0},
         // read ones then a zero in the top bit
         '{OP_READ,      8'h00, 1'b1, 8'd1,  1'b0, 14'd0},
         '{CMD_TICK,     8'h00, 1'b1, 8'd15, 1'b0, 14'd0},
         '{CMD_TICK,     8'h00, 1'b0, 8'd6,  1'b0, 14'd0},
         // stop
         '{OP_STOP,      8'h00, 1'b0, 8'd1,  1'b0, 14'd0},
         '{CMD_TICK,     8'h00, 1'b0, 8'd5,  1'b0, 14'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under reset settings
      foreach (dir_rows[k]) begin
         for (int n = 0; n < dir_rows[k].reps; n++)
            send_word(dir_rows[k].cmd, dir_rows[k].data, dir_rows[k].smp,
                      dir_rows[k].typed, dir_rows[k].want);
      end
      settle_idle();

      // random phases: ticks, timeout, items, calm, squeeze, start/stop only
      run_phase(8'd1,   16'd0,     120, 1'b0, 1'b0, 1'b0);
      run_phase(8'd2,   16'd3,     80,  1'b1, 1'b0, 1'b0);
      run_phase(8'd0,   16'd1,     100, 1'b0, 1'b1, 1'b0);
      run_phase(8'd3,   16'd65535, 70,  1'b0, 1'b0, 1'b0);
      run_phase(8'd255, 16'd2,     100, 1'b0, 1'b0, 1'b1);
      run_phase(8'd1,   16'd2,     60,  1'b0, 1'b0, 1'b0);

      if (err_count == 0) begin
         $display("tb_two_wire_display_serial_master_core: done, clean");
      end else begin
         $display("tb_two_wire_display_serial_master_core: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/twdsm_pkg.sv
design/two_wire_display_serial_master_core.sv
tb/tb_two_wire_display_serial_master_core.sv
